[sv/tod_pkg.sv]
// Shared types and codes for the time-of-day clock with alarm table.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package tod_pkg;

    localparam int KIND_W   = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int KEY_W    = 64;
    localparam int EVENT_W  = 2;
    localparam int SLOT_W   = 3;

    // Limits compared against the counter plus one, so one bit wider than the counter.
    localparam logic [SECOND_W:0] SECOND_LIMIT = 7'd60;
    localparam logic [MINUTE_W:0] MINUTE_LIMIT = 7'd60;
    localparam logic [HOUR_W:0]   HOUR_LIMIT   = 6'd24;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 3'd0,
        KIND_SET     = 3'd1,
        KIND_ADD     = 3'd2,
        KIND_DEL     = 3'd3,
        KIND_DEL_ALL = 3'd4
    } kind_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_STATUS = 2'd0,
        EV_HOUR   = 2'd1,
        EV_ALARM  = 2'd2,
        EV_MINUTE = 2'd3
    } event_t;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [SLOT_W-1:0]   alarm_slot;
        logic [KEY_W-1:0]    alarm_key_out;
        logic [HOUR_W-1:0]   hour_now;
        logic [MINUTE_W-1:0] minute_now;
        logic [SECOND_W-1:0] second_now;
        logic                last;
    } beat_t;

endpackage

`default_nettype wire

[sv/tod_in_if.sv]
// Command channel interface: valid/ready handshake with the input item fields.
// Depends on tod_pkg for field widths.
`default_nettype none

interface tod_in_if;
    logic                          valid;
    logic                          ready;
    logic [tod_pkg::KIND_W-1:0]    kind;
    logic [tod_pkg::HOUR_W-1:0]    set_hour;
    logic [tod_pkg::MINUTE_W-1:0]  set_minute;
    logic [tod_pkg::SECOND_W-1:0]  set_second;
    logic [tod_pkg::KEY_W-1:0]     alarm_key;

    modport source (output valid, kind, set_hour, set_minute, set_second, alarm_key,
                    input ready);
    modport sink   (input valid, kind, set_hour, set_minute, set_second, alarm_key,
                    output ready);
endinterface

`default_nettype wire

[sv/tod_out_if.sv]
// Result channel interface: valid/ready handshake with the result item fields.
// Depends on tod_pkg for field widths.
`default_nettype none

interface tod_out_if;
    logic                          valid;
    logic                          ready;
    logic [tod_pkg::EVENT_W-1:0]   event_res;
    logic [tod_pkg::SLOT_W-1:0]    alarm_slot;
    logic [tod_pkg::KEY_W-1:0]     alarm_key_out;
    logic [tod_pkg::HOUR_W-1:0]    hour_now;
    logic [tod_pkg::MINUTE_W-1:0]  minute_now;
    logic [tod_pkg::SECOND_W-1:0]  second_now;
    logic                          last;

    modport source (output valid, event_res, alarm_slot, alarm_key_out, hour_now,
                    minute_now, second_now, last, input ready);
    modport sink   (input valid, event_res, alarm_slot, alarm_key_out, hour_now,
                    minute_now, second_now, last, output ready);
endinterface

`default_nettype wire

[sv/tod_slot_ram.sv]
// Alarm slot memory: key, hour and minute per slot, one write and one read port,
// registered read data. Depends on tod_pkg for field widths.
`default_nettype none

module tod_slot_ram #(
    parameter int DEPTH    = 8,
    parameter int IDX_W    = 3,
    parameter int SKEY_W   = 64
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [IDX_W-1:0]              waddr,
    input  wire logic [SKEY_W-1:0]             wkey,
    input  wire logic [tod_pkg::HOUR_W-1:0]    whour,
    input  wire logic [tod_pkg::MINUTE_W-1:0]  wminute,
    input  wire logic [IDX_W-1:0]              raddr,
    output logic      [SKEY_W-1:0]             rkey,
    output logic      [tod_pkg::HOUR_W-1:0]    rhour,
    output logic      [tod_pkg::MINUTE_W-1:0]  rminute
);

    logic [SKEY_W-1:0]            mem_key    [DEPTH];
    logic [tod_pkg::HOUR_W-1:0]   mem_hour   [DEPTH];
    logic [tod_pkg::MINUTE_W-1:0] mem_minute [DEPTH];

    logic [SKEY_W-1:0]            rkey_reg;
    logic [tod_pkg::HOUR_W-1:0]   rhour_reg;
    logic [tod_pkg::MINUTE_W-1:0] rminute_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_key[waddr]    <= wkey;
            mem_hour[waddr]   <= whour;
            mem_minute[waddr] <= wminute;
        end
        rkey_reg    <= mem_key[raddr];
        rhour_reg   <= mem_hour[raddr];
        rminute_reg <= mem_minute[raddr];
    end

    assign rkey    = rkey_reg;
    assign rhour   = rhour_reg;
    assign rminute = rminute_reg;

endmodule

`default_nettype wire

[sv/tod_out_buf.sv]
// Result output register: holds one beat until the sink takes it.
// Depends on tod_pkg (beat_t) and tod_out_if.
`default_nettype none

module tod_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tod_pkg::beat_t  beat,
    output logic                 space,
    tod_out_if.source            rsp
);

    logic           vld_reg;
    logic           vld_next;
    tod_pkg::beat_t beat_reg;

    assign space    = !vld_reg || rsp.ready;
    assign vld_next = push || (vld_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            beat_reg <= beat;
        end
    end

    assign rsp.valid         = vld_reg;
    assign rsp.event_res     = beat_reg.event_res;
    assign rsp.alarm_slot    = beat_reg.alarm_slot;
    assign rsp.alarm_key_out = beat_reg.alarm_key_out;
    assign rsp.hour_now      = beat_reg.hour_now;
    assign rsp.minute_now    = beat_reg.minute_now;
    assign rsp.second_now    = beat_reg.second_now;
    assign rsp.last          = beat_reg.last;

endmodule

`default_nettype wire

[sv/time_of_day_clock_with_alarms_top.sv]
// Time-of-day clock with alarm table: control sequencer and time counters.
// Depends on tod_pkg, tod_in_if, tod_out_if, tod_slot_ram and tod_out_buf.
//
//   Channel | Direction | Beat contents
//   cmd     | in        | kind, set_hour, set_minute, set_second, alarm_key
//   rsp     | out       | event_res, alarm_slot, alarm_key_out, hour/minute/second_now, last
//
// A tick without a seconds rollover gives no beat. Set time, delete all and unused
// kinds go straight to a status beat. An add walks the valid bits for a free slot.
// Delete by key and a rollover tick scan the slots through the single memory read
// port, which reads one slot a cycle.
// Reset clears the time and all slot valid bits at once; no clearing pass is needed.
// A stalled result holds the sequencer in its emit state; cmd.ready is low until idle.
`default_nettype none

module time_of_day_clock_with_alarms_top #(
    parameter int ALARM_SLOTS = 8,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tod_in_if.sink     cmd,
    tod_out_if.source  rsp
);

    localparam int IDX_W  = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int SKEY_W = 8 * KEY_BYTES;
    localparam logic [IDX_W:0] SLOTS_CNT = (IDX_W + 1)'(ALARM_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_DEL,
        ST_HOUR,
        ST_ALARM,
        ST_ALMOUT,
        ST_MINUTE,
        ST_STATUS
    } state_t;

    state_t                        state_reg, state_next;
    logic [tod_pkg::SECOND_W-1:0]  sec_reg, sec_next;
    logic [tod_pkg::MINUTE_W-1:0]  min_reg, min_next;
    logic [tod_pkg::HOUR_W-1:0]    hour_reg, hour_next;
    logic [ALARM_SLOTS-1:0]        valid_reg, valid_next;
    logic [IDX_W:0]                scan_idx_reg, scan_idx_next;
    logic                          chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;

    logic [SKEY_W-1:0]             key_reg, key_next;
    logic [tod_pkg::HOUR_W-1:0]    ahour_reg, ahour_next;
    logic [tod_pkg::MINUTE_W-1:0]  amin_reg, amin_next;
    logic [IDX_W-1:0]              found_idx_reg, found_idx_next;
    logic [SKEY_W-1:0]             found_key_reg, found_key_next;

    logic [SKEY_W-1:0]             norm_key;
    logic [tod_pkg::SECOND_W:0]    sec_inc;
    logic [tod_pkg::MINUTE_W:0]    min_inc;
    logic [tod_pkg::HOUR_W:0]      hour_inc;
    logic                          scan_done;
    logic [IDX_W-1:0]              scan_addr;
    logic [6:0]                    found_idx_ext;

    logic                          ram_we;
    logic [SKEY_W-1:0]             rd_key;
    logic [tod_pkg::HOUR_W-1:0]    rd_hour;
    logic [tod_pkg::MINUTE_W-1:0]  rd_minute;

    logic                          push;
    logic                          space;
    tod_pkg::beat_t                beat;

    // Bytes after the first zero byte do not count toward the key.
    always_comb
    begin
        logic alive;
        alive    = 1'b1;
        norm_key = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            alive = alive && (cmd.alarm_key[8*b +: 8] != 8'd0);
            norm_key[8*b +: 8] = alive ? cmd.alarm_key[8*b +: 8] : 8'd0;
        end
    end

    assign sec_inc       = {1'b0, sec_reg} + 1'b1;
    assign min_inc       = {1'b0, min_reg} + 1'b1;
    assign hour_inc      = {1'b0, hour_reg} + 1'b1;
    assign scan_done     = (scan_idx_reg == SLOTS_CNT);
    assign scan_addr     = scan_idx_reg[IDX_W-1:0];
    assign found_idx_ext = 7'(found_idx_reg);
    assign cmd.ready     = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        key_next       = key_reg;
        ahour_next     = ahour_reg;
        amin_next      = amin_reg;
        found_idx_next = found_idx_reg;
        found_key_next = found_key_reg;
        ram_we         = 1'b0;
        push           = 1'b0;

        beat.event_res     = tod_pkg::EV_STATUS;
        beat.alarm_slot    = '0;
        beat.alarm_key_out = '0;
        beat.hour_now      = hour_reg;
        beat.minute_now    = min_reg;
        beat.second_now    = sec_reg;
        beat.last          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next      = norm_key;
                    ahour_next    = cmd.set_hour;
                    amin_next     = cmd.set_minute;
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    case (cmd.kind)
                        tod_pkg::KIND_TICK:
                        begin
                            if (sec_inc < tod_pkg::SECOND_LIMIT)
                            begin
                                sec_next = sec_inc[tod_pkg::SECOND_W-1:0];
                            end
                            else
                            begin
                                sec_next = '0;
                                if (min_inc >= tod_pkg::MINUTE_LIMIT)
                                begin
                                    min_next   = '0;
                                    hour_next  = (hour_inc >= tod_pkg::HOUR_LIMIT) ?
                                                 '0 : hour_inc[tod_pkg::HOUR_W-1:0];
                                    state_next = ST_HOUR;
                                end
                                else
                                begin
                                    min_next   = min_inc[tod_pkg::MINUTE_W-1:0];
                                    state_next = ST_ALARM;
                                end
                            end
                        end
                        tod_pkg::KIND_SET:
                        begin
                            hour_next  = cmd.set_hour;
                            min_next   = cmd.set_minute;
                            sec_next   = cmd.set_second;
                            state_next = ST_STATUS;
                        end
                        tod_pkg::KIND_ADD:
                        begin
                            state_next = (norm_key != '0) ? ST_ADD : ST_STATUS;
                        end
                        tod_pkg::KIND_DEL:
                        begin
                            state_next = ST_DEL;
                        end
                        tod_pkg::KIND_DEL_ALL:
                        begin
                            valid_next = '0;
                            state_next = ST_STATUS;
                        end
                        default:
                        begin
                            state_next = ST_STATUS;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (scan_done)
                begin
                    state_next = ST_STATUS;
                end
                else if (!valid_reg[scan_addr])
                begin
                    ram_we                = 1'b1;
                    valid_next[scan_addr] = 1'b1;
                    state_next            = ST_STATUS;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_DEL:
            begin
                // Reads are issued one slot ahead of the compare.
                if (!scan_done)
                begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_addr;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg && valid_reg[chk_idx_reg] && (rd_key == key_reg))
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
                if (scan_done && !chk_vld_reg)
                begin
                    state_next = ST_STATUS;
                end
            end

            ST_HOUR:
            begin
                if (space)
                begin
                    push           = 1'b1;
                    beat.event_res = tod_pkg::EV_HOUR;
                    state_next     = ST_ALARM;
                end
            end

            ST_ALARM:
            begin
                if (!scan_done)
                begin
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_addr;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg && valid_reg[chk_idx_reg] &&
                    (rd_hour == hour_reg) && (rd_minute == min_reg))
                begin
                    found_idx_next = chk_idx_reg;
                    found_key_next = rd_key;
                    state_next     = ST_ALMOUT;
                end
                else if (scan_done && !chk_vld_reg)
                begin
                    state_next = ST_MINUTE;
                end
            end

            ST_ALMOUT:
            begin
                if (space)
                begin
                    push               = 1'b1;
                    beat.event_res     = tod_pkg::EV_ALARM;
                    beat.alarm_slot    = found_idx_ext[tod_pkg::SLOT_W-1:0];
                    beat.alarm_key_out = tod_pkg::KEY_W'(found_key_reg);
                    state_next         = ST_MINUTE;
                end
            end

            ST_MINUTE:
            begin
                if (space)
                begin
                    push           = 1'b1;
                    beat.event_res = tod_pkg::EV_MINUTE;
                    beat.last      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_STATUS:
            begin
                if (space)
                begin
                    push       = 1'b1;
                    beat.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sec_reg      <= '0;
            min_reg      <= '0;
            hour_reg     <= '0;
            valid_reg    <= '0;
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            valid_reg    <= valid_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        ahour_reg     <= ahour_next;
        amin_reg      <= amin_next;
        found_idx_reg <= found_idx_next;
        found_key_reg <= found_key_next;
    end

    tod_slot_ram #(
        .DEPTH  (ALARM_SLOTS),
        .IDX_W  (IDX_W),
        .SKEY_W (SKEY_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (scan_addr),
        .wkey    (key_reg),
        .whour   (ahour_reg),
        .wminute (amin_reg),
        .raddr   (scan_addr),
        .rkey    (rd_key),
        .rhour   (rd_hour),
        .rminute (rd_minute)
    );

    tod_out_buf u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .beat  (beat),
        .space (space),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

[sv/tod_checker.sv]
// Port-level checks for the time-of-day clock, attached to the top level by bind.
// Depends on tod_pkg for event codes and field widths.
`default_nettype none

module tod_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [tod_pkg::EVENT_W-1:0]   rsp_event,
    input wire logic [tod_pkg::SLOT_W-1:0]    rsp_slot,
    input wire logic [tod_pkg::KEY_W-1:0]     rsp_key,
    input wire logic [tod_pkg::HOUR_W-1:0]    rsp_hour,
    input wire logic [tod_pkg::MINUTE_W-1:0]  rsp_minute,
    input wire logic [tod_pkg::SECOND_W-1:0]  rsp_second,
    input wire logic                          rsp_last
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event) && $stable(rsp_key) &&
        $stable(rsp_slot) && $stable(rsp_hour) && $stable(rsp_minute) &&
        $stable(rsp_second) && $stable(rsp_last))
        else $error("result beat changed while stalled");

    // Status and minute-step beats close an item; hour-step and alarm beats never do.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_last == (rsp_event == tod_pkg::EV_STATUS ||
                                    rsp_event == tod_pkg::EV_MINUTE)))
        else $error("last flag does not match event kind");

    // Only alarm beats carry a slot and a key.
    a_noalarm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_event != tod_pkg::EV_ALARM |-> rsp_slot == '0 && rsp_key == '0)
        else $error("slot or key set on a non-alarm beat");

    // An alarm always carries a nonempty key and arrives on a whole minute.
    a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_event == tod_pkg::EV_ALARM |-> rsp_key[7:0] != 8'd0 &&
        rsp_second == '0)
        else $error("alarm beat with empty key or off the minute");

endmodule

bind time_of_day_clock_with_alarms_top tod_checker u_tod_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_event  (rsp.event_res),
    .rsp_slot   (rsp.alarm_slot),
    .rsp_key    (rsp.alarm_key_out),
    .rsp_hour   (rsp.hour_now),
    .rsp_minute (rsp.minute_now),
    .rsp_second (rsp.second_now),
    .rsp_last   (rsp.last)
);

`default_nettype wire

[sim/tod_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the time-of-day clock: watches both channels, keeps its own clock and
// alarm table, and compares every result beat with the oldest predicted one.
// Depends on tod_pkg, tod_in_if and tod_out_if.

module tod_scoreboard #(
    parameter int ALARM_SLOTS = 8,
    parameter int KEY_BYTES   = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tod_in_if         cmd,
    tod_out_if        rsp,
    output int        errors,
    output int        beats_due
);

    localparam int MAX_REPORTS = 10;

    logic [tod_pkg::SECOND_W-1:0] clk_sec;
    logic [tod_pkg::MINUTE_W-1:0] clk_min;
    logic [tod_pkg::HOUR_W-1:0]   clk_hour;
    logic [tod_pkg::KEY_W-1:0]    slot_key  [ALARM_SLOTS];
    logic [tod_pkg::HOUR_W-1:0]   slot_hour [ALARM_SLOTS];
    logic [tod_pkg::MINUTE_W-1:0] slot_min  [ALARM_SLOTS];
    tod_pkg::beat_t               rsp_due_q [$];

    initial
    begin
        errors    = 0;
        beats_due = 0;
    end

    // Only the low KEY_BYTES bytes count, and everything after the first zero byte is dropped.
    function automatic logic [tod_pkg::KEY_W-1:0] trim_key(input logic [tod_pkg::KEY_W-1:0] raw);
        logic [tod_pkg::KEY_W-1:0] k;
        bit                        ended;
        k     = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES && i < tod_pkg::KEY_W / 8; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic tod_pkg::beat_t time_beat(input tod_pkg::event_t ev,
                                                 input logic [tod_pkg::SLOT_W-1:0] slot,
                                                 input logic [tod_pkg::KEY_W-1:0] key,
                                                 input logic fin);
        tod_pkg::beat_t b;
        b.event_res     = ev;
        b.alarm_slot    = slot;
        b.alarm_key_out = key;
        b.hour_now      = clk_hour;
        b.minute_now    = clk_min;
        b.second_now    = clk_sec;
        b.last          = fin;
        return b;
    endfunction

    function automatic void clear_slot(input int i);
        slot_key[i]  = '0;
        slot_hour[i] = '0;
        slot_min[i]  = '0;
    endfunction

    // Advances the clock and alarm table by one command and queues the beats it causes.
    function automatic void apply_cmd(input logic [tod_pkg::KIND_W-1:0] kind,
                                      input logic [tod_pkg::HOUR_W-1:0] hr,
                                      input logic [tod_pkg::MINUTE_W-1:0] mn,
                                      input logic [tod_pkg::SECOND_W-1:0] sc,
                                      input logic [tod_pkg::KEY_W-1:0] raw_key);
        logic [tod_pkg::SECOND_W:0] sec_inc;
        logic [tod_pkg::MINUTE_W:0] min_inc;
        logic [tod_pkg::HOUR_W:0]   hour_inc;
        logic [tod_pkg::KEY_W-1:0]  key;
        bit                         placed;
        bit                         alarm_hit;
        key       = trim_key(raw_key);
        placed    = 1'b0;
        alarm_hit = 1'b0;
        if (kind == tod_pkg::KIND_TICK)
        begin
            sec_inc = {1'b0, clk_sec} + 1'b1;
            if (sec_inc < tod_pkg::SECOND_LIMIT)
            begin
                clk_sec = sec_inc[tod_pkg::SECOND_W-1:0];
                return;
            end
            clk_sec = '0;
            min_inc = {1'b0, clk_min} + 1'b1;
            if (min_inc >= tod_pkg::MINUTE_LIMIT)
            begin
                clk_min  = '0;
                hour_inc = {1'b0, clk_hour} + 1'b1;
                clk_hour = (hour_inc >= tod_pkg::HOUR_LIMIT) ?
                           '0 : hour_inc[tod_pkg::HOUR_W-1:0];
                rsp_due_q.push_back(time_beat(tod_pkg::EV_HOUR, '0, '0, 1'b0));
            end
            else
            begin
                clk_min = min_inc[tod_pkg::MINUTE_W-1:0];
            end
            // Only the lowest matching slot fires; empty slots never do.
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                if (!alarm_hit && slot_key[i][7:0] != 8'h00 &&
                    slot_hour[i] == clk_hour && slot_min[i] == clk_min)
                begin
                    alarm_hit = 1'b1;
                    rsp_due_q.push_back(time_beat(tod_pkg::EV_ALARM, tod_pkg::SLOT_W'(i),
                                                  slot_key[i], 1'b0));
                end
            end
            rsp_due_q.push_back(time_beat(tod_pkg::EV_MINUTE, '0, '0, 1'b1));
            return;
        end
        case (kind)
            tod_pkg::KIND_SET:
            begin
                clk_hour = hr;
                clk_min  = mn;
                clk_sec  = sc;
            end
            tod_pkg::KIND_ADD:
            begin
                if (key != '0)
                begin
                    for (int i = 0; i < ALARM_SLOTS; i++)
                    begin
                        if (!placed && slot_key[i][7:0] == 8'h00)
                        begin
                            placed       = 1'b1;
                            slot_key[i]  = key;
                            slot_hour[i] = hr;
                            slot_min[i]  = mn;
                        end
                    end
                end
            end
            tod_pkg::KIND_DEL:
            begin
                for (int i = 0; i < ALARM_SLOTS; i++)
                begin
                    if (slot_key[i] == key)
                        clear_slot(i);
                end
            end
            tod_pkg::KIND_DEL_ALL:
            begin
                for (int i = 0; i < ALARM_SLOTS; i++)
                    clear_slot(i);
            end
            default: ;
        endcase
        rsp_due_q.push_back(time_beat(tod_pkg::EV_STATUS, '0, '0, 1'b1));
    endfunction

    function automatic void note_error(input string what, input tod_pkg::beat_t want,
                                       input tod_pkg::beat_t got);
        if (errors < MAX_REPORTS)
            $display("%0t ns %s: ", $time, what,
                     "expected ev=%0d slot=%0d key=%h %0d:%0d:%0d last=%b, ",
                     want.event_res, want.alarm_slot, want.alarm_key_out, want.hour_now,
                     want.minute_now, want.second_now, want.last,
                     "got ev=%0d slot=%0d key=%h %0d:%0d:%0d last=%b",
                     got.event_res, got.alarm_slot, got.alarm_key_out, got.hour_now,
                     got.minute_now, got.second_now, got.last);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tod_pkg::beat_t got;
        tod_pkg::beat_t want;
        if (!rst_n)
        begin
            clk_sec  = '0;
            clk_min  = '0;
            clk_hour = '0;
            for (int i = 0; i < ALARM_SLOTS; i++)
                clear_slot(i);
            rsp_due_q.delete();
            beats_due = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.event_res     = rsp.event_res;
                got.alarm_slot    = rsp.alarm_slot;
                got.alarm_key_out = rsp.alarm_key_out;
                got.hour_now      = rsp.hour_now;
                got.minute_now    = rsp.minute_now;
                got.second_now    = rsp.second_now;
                got.last          = rsp.last;
                if (rsp_due_q.size() == 0)
                begin
                    note_error("result beat with nothing expected", '0, got);
                end
                else
                begin
                    want = rsp_due_q.pop_front();
                    if (got.event_res !== want.event_res ||
                        got.alarm_slot !== want.alarm_slot ||
                        got.alarm_key_out !== want.alarm_key_out ||
                        got.hour_now !== want.hour_now ||
                        got.minute_now !== want.minute_now ||
                        got.second_now !== want.second_now ||
                        got.last !== want.last)
                        note_error("result beat mismatch", want, got);
                end
            end
            if (cmd.valid && cmd.ready)
                apply_cmd(cmd.kind, cmd.set_hour, cmd.set_minute, cmd.set_second,
                          cmd.alarm_key);
            beats_due = rsp_due_q.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top of the time-of-day clock testbench: clock, reset, command and ready stimulus, verdict.
// Depends on tod_pkg, tod_in_if, tod_out_if, tod_scoreboard and the clock top level.

module tb_top;

    localparam int ALARM_SLOTS = 8;
    localparam int KEY_BYTES   = 8;
    localparam int RUN_ITEMS   = 470;
    localparam int CALM_TAIL   = 60;
    localparam int POOL_SIZE   = 6;
    localparam int SETTLE_CYC  = 40;
    localparam int TIMEOUT_NS  = 2_000_000;

    localparam logic [tod_pkg::KIND_W-1:0] FIRST_SPARE_KIND = 3'd5;
    localparam logic [tod_pkg::KIND_W-1:0] LAST_SPARE_KIND  = 3'd7;

    localparam logic [tod_pkg::KEY_W-1:0] KEY_A          = 64'h0000_0000_0000_0041;
    localparam logic [tod_pkg::KEY_W-1:0] KEY_SPLIT      = 64'h4242_0000_4343_4142;
    localparam logic [tod_pkg::KEY_W-1:0] KEY_SPLIT_ALT  = 64'h99FF_EE00_4343_4142;
    localparam logic [tod_pkg::KEY_W-1:0] KEY_LOW_ZERO   = 64'hFFFF_FFFF_FFFF_FF00;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   cmds_sent;
    int   mismatches;
    int   beats_due;

    logic [tod_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        key_len  [POOL_SIZE];

    tod_in_if  cmd_if ();
    tod_out_if rsp_if ();

    time_of_day_clock_with_alarms_top #(
        .ALARM_SLOTS (ALARM_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    tod_scoreboard #(
        .ALARM_SLOTS (ALARM_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .rsp       (rsp_if),
        .errors    (mismatches),
        .beats_due (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [tod_pkg::KEY_W-1:0] fresh_key(input int len);
        logic [tod_pkg::KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < len; i++)
            k[8*i +: 8] = 8'($urandom_range(1, 255));
        return k;
    endfunction

    // Pool key with a zero terminator and random junk after it, where there is room.
    function automatic logic [tod_pkg::KEY_W-1:0] pool_key_raw(input int idx);
        logic [tod_pkg::KEY_W-1:0] raw;
        raw = {$urandom, $urandom};
        if (key_len[idx] >= tod_pkg::KEY_W / 8)
            return key_pool[idx];
        raw[8*key_len[idx] +: 8] = 8'h00;
        for (int i = 0; i < key_len[idx]; i++)
            raw[8*i +: 8] = key_pool[idx][8*i +: 8];
        return raw;
    endfunction

    task automatic send_cmd(input int kind, input int hr, input int mn, input int sc,
                            input logic [tod_pkg::KEY_W-1:0] key);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= tod_pkg::KIND_W'(kind);
        cmd_if.set_hour   <= tod_pkg::HOUR_W'(hr);
        cmd_if.set_minute <= tod_pkg::MINUTE_W'(mn);
        cmd_if.set_second <= tod_pkg::SECOND_W'(sc);
        cmd_if.alarm_key  <= key;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        cmds_sent++;
    endtask

    // A tick carries random junk in the fields it does not use.
    task automatic send_tick();
        send_cmd(tod_pkg::KIND_TICK, $urandom_range(0, 31), $urandom_range(0, 63),
                 $urandom_range(0, 63), {$urandom, $urandom});
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        wait (beats_due == 0);
    endtask

    initial
    begin
        int  choice;
        int  hr;
        int  mn;
        int  prev_hr;
        int  prev_mn;
        int  pick;
        bit  drained_once;

        rst_n             = 1'b0;
        idle_on           = 1'b1;
        cmds_sent         = 0;
        drained_once      = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = tod_pkg::KIND_TICK;
        cmd_if.set_hour   = '0;
        cmd_if.set_minute = '0;
        cmd_if.set_second = '0;
        cmd_if.alarm_key  = '0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_len[i]  = (i == 0) ? tod_pkg::KEY_W / 8 : $urandom_range(1, tod_pkg::KEY_W / 8);
            key_pool[i] = fresh_key(key_len[i]);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part.
        send_tick();
        send_cmd(tod_pkg::KIND_ADD, 0, 2, 0, KEY_A);
        send_cmd(tod_pkg::KIND_ADD, 5, 30, 0, KEY_SPLIT);
        send_cmd(tod_pkg::KIND_ADD, 1, 1, 0, KEY_LOW_ZERO);
        send_cmd(tod_pkg::KIND_SET, 0, 1, 59, '0);
        send_tick();
        send_cmd(tod_pkg::KIND_DEL, 0, 0, 0, KEY_SPLIT_ALT);
        send_cmd(tod_pkg::KIND_ADD, 0, 0, 0, '1);
        send_cmd(tod_pkg::KIND_SET, 23, 59, 59, '0);
        send_tick();
        send_cmd(tod_pkg::KIND_SET, '1, '1, '1, '1);
        send_tick();
        send_cmd(LAST_SPARE_KIND, '1, '1, '1, '1);
        send_cmd(tod_pkg::KIND_DEL_ALL, 0, 0, 0, '0);
        // One more add than there are slots, so the last one is dropped.
        for (int i = 0; i <= ALARM_SLOTS; i++)
            send_cmd(tod_pkg::KIND_ADD, $urandom_range(0, 23), $urandom_range(0, 59), 0,
                     fresh_key($urandom_range(1, tod_pkg::KEY_W / 8)));
        send_cmd(tod_pkg::KIND_DEL_ALL, '1, '1, '1, '1);

        // Random part: the most common item is an alarm sequence that approaches a minute boundary.
        while (cmds_sent < RUN_ITEMS)
        begin
            if (cmds_sent >= RUN_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            else if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            if (!drained_once && cmds_sent >= RUN_ITEMS / 2)
            begin
                wait_results_drained();
                drained_once = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 40)
            begin
                hr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 23);
                mn = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 59);
                pick = $urandom_range(0, POOL_SIZE - 1);
                send_cmd(tod_pkg::KIND_ADD, hr, mn, $urandom_range(0, 63), pool_key_raw(pick));
                if ($urandom_range(0, 2) == 0)
                    send_cmd(tod_pkg::KIND_ADD, hr, mn, $urandom_range(0, 63),
                             pool_key_raw($urandom_range(0, POOL_SIZE - 1)));
                if (mn == 0)
                begin
                    prev_mn = 59;
                    prev_hr = (hr == 0) ? 23 : hr - 1;
                end
                else
                begin
                    prev_mn = mn - 1;
                    prev_hr = hr;
                end
                send_cmd(tod_pkg::KIND_SET, prev_hr, prev_mn, $urandom_range(57, 59),
                         {$urandom, $urandom});
                repeat ($urandom_range(1, 3)) send_tick();
            end
            else if (choice < 58)
            begin
                send_cmd(tod_pkg::KIND_DEL, $urandom_range(0, 31), $urandom_range(0, 63),
                         $urandom_range(0, 63), pool_key_raw($urandom_range(0, POOL_SIZE - 1)));
            end
            else if (choice < 64)
            begin
                send_cmd(tod_pkg::KIND_DEL_ALL, $urandom_range(0, 31), $urandom_range(0, 63),
                         $urandom_range(0, 63), {$urandom, $urandom});
            end
            else if (choice < 78)
            begin
                repeat ($urandom_range(1, 5)) send_tick();
            end
            else if (choice < 86)
            begin
                send_cmd(tod_pkg::KIND_SET, $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59), {$urandom, $urandom});
            end
            else if (choice < 94)
            begin
                // Noise: any kind, any field value, spare kinds included.
                send_cmd($urandom_range(tod_pkg::KIND_TICK, LAST_SPARE_KIND),
                         $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                         {$urandom, $urandom});
            end
            else if (choice < 97)
            begin
                send_cmd($urandom_range(FIRST_SPARE_KIND, LAST_SPARE_KIND),
                         $urandom_range(0, 31), $urandom_range(0, 63),
                         $urandom_range(0, 63), {$urandom, $urandom});
            end
            else
            begin
                send_cmd(tod_pkg::KIND_ADD, $urandom_range(0, 31), $urandom_range(0, 63),
                         $urandom_range(0, 63), {$urandom, $urandom});
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0 && beats_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[time_of_day_clock_with_alarms_top.f]
sv/tod_pkg.sv
sv/tod_in_if.sv
sv/tod_out_if.sv
sv/tod_slot_ram.sv
sv/tod_out_buf.sv
sv/time_of_day_clock_with_alarms_top.sv
sv/tod_checker.sv
sim/tod_checker.sv
sim/tb_top.sv
